/* sv/sample_mean_and_stddev_core_macros.svh */
`ifndef SAMPLE_MEAN_AND_STDDEV_CORE_MACROS_SVH
`define SAMPLE_MEAN_AND_STDDEV_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SMSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smsd assertion failed");

// Property whose consequence is checked in the cycle after its trigger.
`define SMSD_ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("smsd assertion failed");

`endif

/* sv/smsd_pkg.sv */
`timescale 1ns / 1ps
package smsd_pkg;
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W = 13;
  localparam int SUM_W = 36;
  localparam int SQ_W = 60;

  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]        sumsq;
    logic                   overflow;
  } smsd_set_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_SQ, ST_MUL_NQ, ST_SQRT, ST_DIV_SD, ST_DIV_MEAN, ST_OUT
  } smsd_state_t;
endpackage

/* sv/smsd_front.sv */
`timescale 1ns / 1ps
module smsd_front import smsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  output logic                push,
  output smsd_set_t           push_data
);
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    drop_r, drop_nxt;
  logic signed [2*SAMPLE_W-1:0] sq_term;

  assign sq_term = $signed(sample) * $signed(sample);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    drop_nxt  = drop_r;
    if (count_r < COUNT_W'(MAX_SAMPLES)) begin
      count_nxt = count_r + COUNT_W'(1);
      sum_nxt   = sum_r + SUM_W'($signed(sample));
      sq_nxt    = sq_r + SQ_W'($unsigned(sq_term));
    end else begin
      drop_nxt = 1'b1;
    end
  end

  assign push = accept && last;
  assign push_data = '{count: count_nxt, sum: sum_nxt, sumsq: sq_nxt, overflow: drop_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      drop_r  <= drop_nxt;
    end
  end
endmodule

/* sv/smsd_queue.sv */
`timescale 1ns / 1ps
module smsd_queue import smsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  smsd_set_t push_data,
  input  logic      pop,
  output smsd_set_t head,
  output logic      empty,
  output logic      full
);
  smsd_set_t   mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  fill_r;

  assign empty = (fill_r == 2'd0);
  assign full  = (fill_r == 2'd2);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* sv/smsd_back.sv */
`timescale 1ns / 1ps
module smsd_back import smsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  smsd_set_t   q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] mean,
  output logic [31:0] stddev,
  output logic [COUNT_W-1:0] count,
  output logic        overflow
);
  localparam int PW = 72;
  localparam int RW = 88;
  localparam int QW = 44;

  smsd_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [PW-1:0] mul_a_r, mul_a_nxt, acc_r, acc_nxt, s2_r, s2_nxt;
  logic [SQ_W-1:0] mul_b_r, mul_b_nxt;
  logic [RW-1:0] rad_r, rad_nxt;
  logic [46:0] rem_r, rem_nxt, rem_sh, trial;
  logic [QW-1:0] root_r, root_nxt, dq_r, dq_nxt;
  logic [13:0] drem_r, drem_nxt, drem_sh;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic neg_r, neg_nxt, ovf_r, ovf_nxt;
  logic [SUM_W-1:0] mag_r, mag_nxt;
  logic [SQ_W-1:0] q_r, q_nxt;
  logic [31:0] mean_r, mean_nxt, sd_r, sd_nxt;
  logic [PW-1:0] acc_step, diff;
  logic [46:0] rem_step;
  logic [QW-1:0] root_step, dq_step;
  logic [13:0] drem_step;

  always_comb begin
    acc_step = mul_b_r[0] ? acc_r + mul_a_r : acc_r;
    diff     = acc_step - s2_r;
    rem_sh   = {rem_r[44:0], rad_r[RW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_step  = rem_sh - trial;
      root_step = {root_r[QW-2:0], 1'b1};
    end else begin
      rem_step  = rem_sh;
      root_step = {root_r[QW-2:0], 1'b0};
    end
    drem_sh = {drem_r[12:0], dq_r[QW-1]};
    if (drem_sh >= {1'b0, n_r}) begin
      drem_step = drem_sh - {1'b0, n_r};
      dq_step   = {dq_r[QW-2:0], 1'b1};
    end else begin
      drem_step = drem_sh;
      dq_step   = {dq_r[QW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r - 6'd1;
    mul_a_nxt = mul_a_r;  mul_b_nxt = mul_b_r;  acc_nxt = acc_r;  s2_nxt = s2_r;
    rad_nxt = rad_r;  rem_nxt = rem_r;  root_nxt = root_r;
    dq_nxt = dq_r;  drem_nxt = drem_r;
    n_nxt = n_r;  neg_nxt = neg_r;  ovf_nxt = ovf_r;  mag_nxt = mag_r;  q_nxt = q_r;
    mean_nxt = mean_r;  sd_nxt = sd_r;
    pop = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = cnt_r;
        if (!q_empty) begin
          pop = 1'b1;
          n_nxt = q_head.count;
          q_nxt = q_head.sumsq;
          ovf_nxt = q_head.overflow;
          neg_nxt = q_head.sum[SUM_W-1];
          mag_nxt = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
          mul_a_nxt = PW'(mag_nxt);
          mul_b_nxt = SQ_W'(mag_nxt);
          acc_nxt = '0;
          cnt_nxt = 6'(SUM_W);
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        acc_nxt = acc_step;
        mul_a_nxt = mul_a_r << 1;
        mul_b_nxt = mul_b_r >> 1;
        if (cnt_r == 6'd1) begin
          s2_nxt = acc_step;
          mul_a_nxt = PW'(q_r);
          mul_b_nxt = SQ_W'(n_r);
          acc_nxt = '0;
          cnt_nxt = 6'(COUNT_W);
          state_nxt = ST_MUL_NQ;
        end
      end
      ST_MUL_NQ: begin
        acc_nxt = acc_step;
        mul_a_nxt = mul_a_r << 1;
        mul_b_nxt = mul_b_r >> 1;
        if (cnt_r == 6'd1) begin
          rad_nxt = {diff, 16'd0};
          rem_nxt = '0;
          root_nxt = '0;
          cnt_nxt = 6'(RW / 2);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_nxt = rad_r << 2;
        rem_nxt = rem_step;
        root_nxt = root_step;
        if (cnt_r == 6'd1) begin
          dq_nxt = root_step;
          drem_nxt = '0;
          cnt_nxt = 6'(QW);
          state_nxt = ST_DIV_SD;
        end
      end
      ST_DIV_SD: begin
        dq_nxt = dq_step;
        drem_nxt = drem_step;
        if (cnt_r == 6'd1) begin
          sd_nxt = (dq_step[QW-1:32] != '0) ? '1 : dq_step[31:0];
          dq_nxt = {mag_r[QW-9:0], 8'd0};
          drem_nxt = '0;
          cnt_nxt = 6'(QW);
          state_nxt = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        dq_nxt = dq_step;
        drem_nxt = drem_step;
        if (cnt_r == 6'd1) begin
          mean_nxt = neg_r ? -dq_step[31:0] : dq_step[31:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cnt_nxt = cnt_r;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r <= mul_a_nxt;  mul_b_r <= mul_b_nxt;  acc_r <= acc_nxt;  s2_r <= s2_nxt;
    rad_r <= rad_nxt;  rem_r <= rem_nxt;  root_r <= root_nxt;
    dq_r <= dq_nxt;  drem_r <= drem_nxt;
    n_r <= n_nxt;  neg_r <= neg_nxt;  ovf_r <= ovf_nxt;  mag_r <= mag_nxt;  q_r <= q_nxt;
    mean_r <= mean_nxt;  sd_r <= sd_nxt;
  end

  assign out_valid = (state_r == ST_OUT);
  assign mean = mean_r;
  assign stddev = sd_r;
  assign count = n_r;
  assign overflow = ovf_r;
endmodule

/* sv/sample_mean_and_stddev_core.sv */
`timescale 1ns / 1ps
// Mean and population standard deviation of sets of signed 24-bit samples, a set ending
// at the transaction with in_tlast high. The accumulator takes one sample per clock
// while in_tready is high; finished sets wait in a two-entry queue for the back end,
// which works through one set at a time (a load, 36 + 13 shift-add multiply steps,
// 44 square root steps and two 44-step restoring divisions, then the output) and
// holds its result while out_tready is low. When sets arrive faster than the back
// end finishes them, the queue fills and in_tready drops until the back end catches up.
module sample_mean_and_stddev_core import smsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] mean_fixed, [63:32] stddev_fixed, [76:64] count
  output logic        out_tuser   // [0] overflow
);
  logic      accept, push, pop, q_empty, q_full;
  smsd_set_t push_data, q_head;
  logic [31:0] mean, stddev;
  logic [COUNT_W-1:0] count;

  assign in_tready = !q_full;
  assign accept = in_tvalid && in_tready;

  smsd_front u_front (
    .clk, .rst_n, .accept, .sample(in_tdata), .last(in_tlast), .push, .push_data
  );

  smsd_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head(q_head), .empty(q_empty), .full(q_full)
  );

  smsd_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .pop, .out_valid(out_tvalid), .out_ready(out_tready),
    .mean, .stddev, .count, .overflow(out_tuser)
  );

  assign out_tdata = {3'd0, count, stddev, mean};
endmodule

/* sv/smsd_checker.sv */
`timescale 1ns / 1ps
`include "sample_mean_and_stddev_core_macros.svh"
module smsd_checker import smsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser
);
  `SMSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SMSD_ASSERT(a_count_nonzero, clk, rst_n, out_tvalid |-> out_tdata[76:64] != 13'd0)
  `SMSD_ASSERT(a_ovf_full, clk, rst_n, (out_tvalid && out_tuser) |-> out_tdata[76:64] == 13'(MAX_SAMPLES))
  `SMSD_ASSERT(a_count_max, clk, rst_n, out_tvalid |-> out_tdata[76:64] <= 13'(MAX_SAMPLES))
endmodule

bind sample_mean_and_stddev_core smsd_checker u_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

/* dv/sample_mean_and_stddev_core_tb.sv */
`timescale 1ns / 1ps
module sample_mean_and_stddev_core_tb;
  import smsd_pkg::*;

  typedef struct {
    logic [23:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct {
    logic [31:0] mean_fixed;
    logic [31:0] stddev_fixed;
    logic [12:0] count;
    logic        overflow;
  } set_stats_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        out_tuser;

  sample_mean_and_stddev_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  sample_item_t sample_queue[$];
  set_stats_t   expected_stats[$];

  // Running state of the set being accumulated.
  logic [12:0]        acc_count;
  logic signed [35:0] acc_sum;
  logic [59:0]        acc_sumsq;
  logic               acc_dropped;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int mismatch_count;
  bit pause_sender;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= x) root = cand;
    end
    return root;
  endfunction

  // Accumulates one sample; returns 1 with the set statistics when the set closes.
  function automatic bit accumulate_sample(sample_item_t it, output set_stats_t st);
    logic signed [63:0]  s;
    logic signed [63:0]  sum64;
    logic signed [63:0]  mean;
    logic [127:0]        n_q;
    logic [127:0]        s_sq;
    logic [127:0]        mag;
    logic [63:0]         root;
    logic [63:0]         sd;
    s = {{40{it.sample[23]}}, it.sample};
    if (acc_count < MAX_SAMPLES) begin
      acc_count = acc_count + 1;
      acc_sum = acc_sum + s;
      acc_sumsq = acc_sumsq + 60'(s * s);
    end else begin
      acc_dropped = 1'b1;
    end
    if (!it.last) return 0;
    sum64 = {{28{acc_sum[35]}}, acc_sum};
    mean = (sum64 * 256) / $signed({51'd0, acc_count});
    mag = sum64 < 0 ? 128'(-sum64) : 128'(sum64);
    n_q = 128'(acc_count) * 128'(acc_sumsq);
    s_sq = mag * mag;
    root = isqrt128((n_q - s_sq) << 16);
    sd = root / 64'(acc_count);
    st.mean_fixed = mean[31:0];
    st.stddev_fixed = sd > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sd[31:0];
    st.count = acc_count;
    st.overflow = acc_dropped;
    acc_count = '0;
    acc_sum = '0;
    acc_sumsq = '0;
    acc_dropped = 1'b0;
    return 1;
  endfunction

  // Driver
  always @(posedge clk) begin
    sample_item_t it;
    set_stats_t   st;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        it.sample = in_tdata;
        it.last = in_tlast;
        if (accumulate_sample(it, st)) expected_stats.push_back(st);
      end
      if ((!in_tvalid || in_tready) ) begin
        if (sample_queue.size() > 0 && !pause_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          it = sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.sample;
          in_tlast <= it.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor
  always @(posedge clk) begin
    set_stats_t exp_st;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_stats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result: %h", out_tdata);
        end else begin
          exp_st = expected_stats.pop_front();
          if (out_tdata[31:0] !== exp_st.mean_fixed || out_tdata[63:32] !== exp_st.stddev_fixed
              || out_tdata[76:64] !== exp_st.count || out_tuser !== exp_st.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: exp mean %h sd %h n %0d ovf %b, got mean %h sd %h n %0d ovf %b",
                       exp_st.mean_fixed, exp_st.stddev_fixed, exp_st.count, exp_st.overflow,
                       out_tdata[31:0], out_tdata[63:32], out_tdata[76:64], out_tuser);
          end
        end
      end
      out_tready <= hold_off_cycles == 0 && $urandom_range(99) >= recv_idle_pct;
    end
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(signed'($urandom_range(200)) - 100);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_set(int len, bit extremes);
    sample_item_t it;
    logic [23:0]  base;
    base = rand_sample();
    for (int i = 0; i < len; i++) begin
      it.sample = extremes ? base : rand_sample();
      it.last = (i == len - 1);
      sample_queue.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_tvalid || expected_stats.size() > 0) @(posedge clk);
  endtask

  initial begin
    sample_item_t it;
    int           len;
    int           sent;
    clk = 1'b0;
    acc_count = '0;
    acc_sum = '0;
    acc_sumsq = '0;
    acc_dropped = 1'b0;
    mismatch_count = 0;
    pause_sender = 1'b0;
    hold_off_cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 51;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-sample sets at the extremes, constant sets, mixed extremes.
    it.last = 1'b1;
    it.sample = 24'h7FFFFF; sample_queue.push_back(it);
    it.sample = 24'h800000; sample_queue.push_back(it);
    it.sample = 24'h000000; sample_queue.push_back(it);
    it.sample = 24'hFFFFFF; sample_queue.push_back(it);
    it.last = 1'b0; it.sample = 24'h7FFFFF; sample_queue.push_back(it);
    it.last = 1'b1; it.sample = 24'h800000; sample_queue.push_back(it);
    it.last = 1'b0; it.sample = 24'h800000; sample_queue.push_back(it);
    it.last = 1'b1; it.sample = 24'h800000; sample_queue.push_back(it);
    it.last = 1'b0; it.sample = 24'hFFFFFF; sample_queue.push_back(it);
    it.last = 1'b0; it.sample = 24'h000002; sample_queue.push_back(it);
    it.last = 1'b1; it.sample = 24'hFFFFFE; sample_queue.push_back(it);
    push_set(5, 1'b1);
    push_set(6, 1'b0);
    wait_drained();

    // Random sets: three idling phases, long hold-off and a sender pause in the first.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 16 : (ph == 1 ? 51 : 0);
      recv_idle_pct = ph == 0 ? 51 : (ph == 1 ? 16 : 0);
      sent = 0;
      if (ph == 0) hold_off_cycles = 3000;
      while (sent < 370) begin
        len = $urandom_range(9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 8);
        push_set(len, $urandom_range(7) == 0);
        sent += len;
        if (ph == 0 && sent > 150 && sent < 170) begin
          wait_drained();
          pause_sender = 1'b1;
          repeat (50) @(posedge clk);
          pause_sender = 1'b0;
        end
      end
      wait_drained();
    end
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
